// ----- src/w8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// w8u16_pkg
// Types and constants shared by the WTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package w8u16_pkg;

  localparam logic [7:0]  LEAD_MIN      = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
  localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
  localparam logic [7:0]  LEAD4_MAX     = 8'hF4;
  localparam logic [7:0]  ASCII_MAX     = 8'h7F;
  localparam logic [1:0]  CONT_TAG      = 2'b10;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] CP_BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;

  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [7:0]  lead_byte;
    logic [20:0] partial_point;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        error;
    logic        last_in_run;
    logic        end_of_string;
  } result_t;

  typedef struct packed {
    logic [1:0]  num_results;
    result_t     res0;
    result_t     res1;
    dec_state_t  state_next;
  } dec_out_t;

endpackage

// ----- src/w8u16_if.sv -----
// ----------------------------------------------------------------------------
// w8u16 channel interfaces
// Valid/ready channels for input bytes and output code units.
// ----------------------------------------------------------------------------
interface w8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface w8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        error;
  logic        last_in_run;
  logic        end_of_string;

  modport source (output valid, output code_unit, output error, output last_in_run,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input error, input last_in_run,
                  input end_of_string, output ready);
endinterface

// ----- src/w8u16_decode.sv -----
// ----------------------------------------------------------------------------
// w8u16_decode
// Single-byte WTF-8 decode step: next state and up to two UTF-16 results.
// ----------------------------------------------------------------------------
module w8u16_decode (
  input  logic [7:0]           byte_in,
  input  w8u16_pkg::dec_state_t state,
  output w8u16_pkg::dec_out_t   dec
);
  import w8u16_pkg::*;

  logic [20:0] pp_shift;
  logic [1:0]  pend_dec;
  logic [20:0] cp;
  logic        cp_bad;
  logic [20:0] v;
  result_t     err_res;

  assign pp_shift = {state.partial_point[14:0], byte_in[5:0]};
  assign pend_dec = state.bytes_pending - 2'd1;
  assign v        = cp - CP_SUPP_BASE;

  always_comb begin
    if (state.lead_byte <= LEAD2_MAX) begin
      cp     = {10'd0, pp_shift[10:0]};
      cp_bad = 1'b0;
    end else if (state.lead_byte <= LEAD3_MAX) begin
      cp     = {5'd0, pp_shift[15:0]};
      cp_bad = 1'b0;
    end else begin
      cp     = pp_shift;
      cp_bad = (state.lead_byte > LEAD4_MAX) || (pp_shift > CP_MAX);
    end
  end

  always_comb begin
    err_res = '{code_unit: 16'd0, error: 1'b1, last_in_run: 1'b1, end_of_string: 1'b0};
    dec             = '0;
    dec.state_next  = state;
    if (state.bytes_pending == 2'd0) begin
      if (byte_in <= ASCII_MAX) begin
        dec.num_results = 2'd1;
        dec.res0 = '{code_unit: {8'd0, byte_in}, error: 1'b0, last_in_run: 1'b1,
                     end_of_string: (byte_in == 8'd0)};
      end else if (byte_in < LEAD_MIN) begin
        dec.num_results = 2'd1;
        dec.res0        = err_res;
        dec.state_next  = '0;
      end else begin
        dec.state_next.lead_byte = byte_in;
        if (byte_in inside {[LEAD_MIN:LEAD2_MAX]}) begin
          dec.state_next.bytes_pending = 2'd1;
          dec.state_next.partial_point = {16'd0, byte_in[4:0]};
        end else if (byte_in <= LEAD3_MAX) begin
          dec.state_next.bytes_pending = 2'd2;
          dec.state_next.partial_point = {17'd0, byte_in[3:0]};
        end else begin
          dec.state_next.bytes_pending = 2'd3;
          dec.state_next.partial_point = {18'd0, byte_in[2:0]};
        end
      end
    end else if (byte_in[7:6] != CONT_TAG) begin
      dec.num_results = 2'd1;
      dec.res0        = err_res;
      dec.state_next  = '0;
    end else if (pend_dec != 2'd0) begin
      dec.state_next.bytes_pending = pend_dec;
      dec.state_next.partial_point = pp_shift;
    end else begin
      dec.state_next = '0;
      if (cp_bad) begin
        dec.num_results = 2'd1;
        dec.res0        = err_res;
      end else if (cp > CP_BMP_MAX) begin
        dec.num_results = 2'd2;
        dec.res0 = '{code_unit: {HI_SURR_TAG, v[19:10]}, error: 1'b0, last_in_run: 1'b0,
                     end_of_string: 1'b0};
        dec.res1 = '{code_unit: {LO_SURR_TAG, v[9:0]}, error: 1'b0, last_in_run: 1'b1,
                     end_of_string: 1'b0};
      end else begin
        dec.num_results = 2'd1;
        dec.res0 = '{code_unit: cp[15:0], error: 1'b0, last_in_run: 1'b1,
                     end_of_string: 1'b0};
      end
    end
  end

endmodule

// ----- src/wtf8_to_utf16_transcoder_core.sv -----
// ----------------------------------------------------------------------------
// wtf8_to_utf16_transcoder_core
// WTF-8 byte stream in, UTF-16 code units out.
// ----------------------------------------------------------------------------
// Channels: bytes carries one WTF-8 byte per item (valid/ready); units carries
// one UTF-16 code unit per item with error, last_in_run and end_of_string.
// A byte is accepted at a rising edge with valid and ready both high.
// Each byte is decoded in the cycle it is accepted; its results are registered
// into a four-entry output queue and appear on units from the queue head.
// Throughput: one byte per cycle while bytes.ready is high. A four-byte
// sequence above U+FFFF gives two units, popped one per cycle on units.ready.
// bytes.ready is high while the queue holds at most two units, so a byte is
// taken while earlier units still wait at the output.
// When the receiver stalls, the queue fills and bytes.ready drops; nothing
// is lost or repeated.
// Reset (rst, synchronous, active high) empties the queue and returns the
// decoder to idle with no sequence open.
// ----------------------------------------------------------------------------
module wtf8_to_utf16_transcoder_core (
  input  logic        clk,
  input  logic        rst,
  w8u16_byte_if.sink   bytes,
  w8u16_unit_if.source units
);
  import w8u16_pkg::*;

  dec_state_t          state;
  dec_out_t            dec;
  result_t             fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_AW:0]    count;
  logic [FIFO_AW:0]    count_next;
  logic                push;
  logic                pop;
  logic [FIFO_AW-1:0]  wr_ptr_1;
  result_t             head;

  w8u16_decode u_decode (
    .byte_in (bytes.byte_in),
    .state   (state),
    .dec     (dec)
  );

  assign bytes.ready = (count < (FIFO_AW+1)'(FIFO_DEPTH - 1));
  assign push        = bytes.valid && bytes.ready;
  assign pop         = units.valid && units.ready;
  assign wr_ptr_1    = wr_ptr + FIFO_AW'(1);

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count_next + {{(FIFO_AW-1){1'b0}}, dec.num_results};
    end
    if (pop) begin
      count_next = count_next - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        state  <= dec.state_next;
        wr_ptr <= wr_ptr + FIFO_AW'(dec.num_results);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (dec.num_results != 2'd0)) begin
      fifo[wr_ptr] <= dec.res0;
    end
    if (push && (dec.num_results == 2'd2)) begin
      fifo[wr_ptr_1] <= dec.res1;
    end
  end

  assign head                = fifo[rd_ptr];
  assign units.valid         = (count != '0);
  assign units.code_unit     = head.code_unit;
  assign units.error         = head.error;
  assign units.last_in_run   = head.last_in_run;
  assign units.end_of_string = head.end_of_string;

endmodule
